[hdl/foah_pkg.sv]
// shared types, constants and elaboration-time table math for the facet histogram
`timescale 1ns / 1ps
package foah_pkg;

    localparam int NRM_W   = 16;
    localparam int CRD_W   = 32;
    localparam int BIN_W   = 6;
    localparam int AREA_W  = 48;
    localparam int TOTAL_W = 64;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    // one triangle's vertices
    typedef struct packed {
        logic [CRD_W-1:0] a_x;
        logic [CRD_W-1:0] a_y;
        logic [CRD_W-1:0] a_z;
        logic [CRD_W-1:0] b_x;
        logic [CRD_W-1:0] b_y;
        logic [CRD_W-1:0] b_z;
        logic [CRD_W-1:0] c_x;
        logic [CRD_W-1:0] c_y;
        logic [CRD_W-1:0] c_z;
    } vtx_t;

    // classified triangle waiting for the accumulate stage
    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [AREA_W-1:0] area;
    } qent_t;

    // restoring long division, used only for constant tables
    function automatic logic [127:0] udiv128(input logic [127:0] n, input logic [127:0] dv);
        logic [127:0] q;
        logic [127:0] r;
        q = '0;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            r = {r[126:0], n[i]};
            if (r >= dv) begin
                r = r - dv;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        pr = {64'b0, a} * {64'b0, b};
        return pr[125:62];
    endfunction

    // squared sine of the midpoint angle 90*p/d degrees, Q2.62
    function automatic logic [63:0] mid_sin_sq(input int unsigned p, input int unsigned d);
        logic [127:0] w;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  s;
        if (p == 0) return 64'd0;
        if (3 * p == d) return 64'd1 << 60;
        if (2 * p == d) return 64'd1 << 61;
        if (3 * p == 2 * d) return 64'd3 << 60;
        w    = udiv128({64'b0, PI_Q62} * 128'(p), 128'(2 * d));
        x    = w[63:0];
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 13; k++) begin
            w    = udiv128({64'b0, mul_q62(term, x2)}, 128'((2 * k) * (2 * k + 1)));
            term = w[63:0];
            if ((k % 2) == 1) sum = sum - term;
            else sum = sum + term;
        end
        s = mul_q62(sum, sum);
        return (s > (64'd1 << 62)) ? (64'd1 << 62) : s;
    endfunction

endpackage

[hdl/foah_binsel.sv]
// elevation bin selection: scans the midpoint table, one probe per cycle
`timescale 1ns / 1ps
module foah_binsel #(
    parameter int BINS = 37
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [foah_pkg::NRM_W-1:0]   nx,
    input  logic signed [foah_pkg::NRM_W-1:0]   ny,
    input  logic signed [foah_pkg::NRM_W-1:0]   nz,
    output logic                                done,
    output logic [foah_pkg::BIN_W-1:0]          bin
);
    localparam int D  = BINS - 1;
    localparam int JW = (D > 1) ? $clog2(D) : 1;

    // midpoint table and which midpoints lie below zero
    logic [62:0] s_tab [D];
    logic        neg_tab [D];

    for (genvar g = 0; g < D; g++) begin : g_tab
        localparam int T = 2 * g + 1 - D;
        localparam int unsigned P = (T < 0) ? -T : T;
        localparam logic [63:0] SV = foah_pkg::mid_sin_sq(P, D);
        assign s_tab[g]   = SV[62:0];
        assign neg_tab[g] = (T < 0);
    end

    logic signed [31:0] sqx, sqy, sqz;
    logic [31:0]        n2_next;

    logic [30:0]        z2_reg;
    logic [31:0]        n2_reg;
    logic               zneg_reg;
    logic               zero_reg;
    logic               run_reg;
    logic [JW-1:0]      j_reg;
    logic               v1_reg;
    logic               last1_reg;
    logic               mneg1_reg;
    logic [62:0]        ph_reg;
    logic [63:0]        pl_reg;
    logic [foah_pkg::BIN_W-1:0] cnt_reg;
    logic               done_reg;

    logic [94:0]        rhs, lhs;
    logic               inc;

    assign sqx     = nx * nx;
    assign sqy     = ny * ny;
    assign sqz     = nz * nz;
    assign n2_next = sqx + sqy + sqz;

    assign rhs = {ph_reg, 32'b0} + {31'b0, pl_reg};
    assign lhs = {2'b0, z2_reg, 62'b0};
    assign inc = zneg_reg ? (mneg1_reg && (lhs <= rhs)) : (mneg1_reg || (lhs > rhs));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            j_reg     <= '0;
        end else begin
            if (start) begin
                run_reg  <= 1'b1;
                j_reg    <= '0;
                cnt_reg  <= '0;
                done_reg <= 1'b0;
                z2_reg   <= sqz[30:0];
                n2_reg   <= n2_next;
                zneg_reg <= nz[foah_pkg::NRM_W-1];
                zero_reg <= (n2_next == 32'd0);
            end else begin
                if (run_reg) begin
                    if (j_reg == JW'(D - 1)) run_reg <= 1'b0;
                    else j_reg <= j_reg + 1'b1;
                end
                if (v1_reg) begin
                    cnt_reg <= cnt_reg + {{(foah_pkg::BIN_W-1){1'b0}}, inc};
                    if (last1_reg) done_reg <= 1'b1;
                end
            end
            v1_reg    <= run_reg && !start;
            last1_reg <= run_reg && (j_reg == JW'(D - 1));
        end
    end

    // probe products, split high and low halves of the table value
    always_ff @(posedge aclk) begin
        mneg1_reg <= neg_tab[j_reg];
        ph_reg    <= {32'b0, s_tab[j_reg][62:32]} * {31'b0, n2_reg};
        pl_reg    <= {32'b0, s_tab[j_reg][31:0]} * {32'b0, n2_reg};
    end

    assign done = done_reg;
    assign bin  = zero_reg ? '0 : cnt_reg;

endmodule

[hdl/foah_area.sv]
// triangle area: cross product squared on one shared multiplier, then bit-serial root
`timescale 1ns / 1ps
module foah_area (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  foah_pkg::vtx_t                vtx,
    output logic                          done,
    output logic [foah_pkg::AREA_W-1:0]   area
);
    typedef enum logic [1:0] {A_IDLE, A_CROSS, A_LOAD, A_SQRT} ph_t;
    typedef enum logic [2:0] {S_P1, S_P2, S_DIFF, S_HH, S_HL, S_LL, S_ACC} sub_t;

    localparam logic [1:0] CMP_X = 2'd0;
    localparam logic [1:0] CMP_Y = 2'd1;
    localparam logic [1:0] CMP_Z = 2'd2;
    localparam int SQRT_STEPS = foah_pkg::AREA_W;

    ph_t  ph_reg;
    sub_t sub_reg;
    logic [1:0] comp_reg;

    logic signed [32:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [32:0] oa, ob, oc, od;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg, p1_reg;
    logic signed [68:0] diff, mabs;
    logic [64:0]        m_reg;
    logic [131:0]       acc_reg, acc_add;

    logic [95:0] rad_reg;
    logic [49:0] rem_reg;
    logic [47:0] root_reg;
    logic [5:0]  it_reg;
    logic        sat_reg;
    logic        done_reg;
    logic [51:0] trial, shifted;

    // operands for the three cross-product components
    always_comb begin
        unique case (comp_reg)
            CMP_X: begin oa = uy_reg; ob = vz_reg; oc = uz_reg; od = vy_reg; end
            CMP_Y: begin oa = uz_reg; ob = vx_reg; oc = ux_reg; od = vz_reg; end
            CMP_Z: begin oa = ux_reg; ob = vy_reg; oc = uy_reg; od = vx_reg; end
            default: begin oa = '0; ob = '0; oc = '0; od = '0; end
        endcase
    end

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        acc_add = '0;
        unique case (sub_reg)
            S_P1: begin mul_a = {oa[32], oa}; mul_b = {ob[32], ob}; end
            S_P2: begin mul_a = {oc[32], oc}; mul_b = {od[32], od}; end
            S_HH: begin mul_a = {2'b0, m_reg[64:33]}; mul_b = {2'b0, m_reg[64:33]}; end
            S_HL: begin
                mul_a   = {2'b0, m_reg[64:33]};
                mul_b   = {1'b0, m_reg[32:0]};
                acc_add = {prod_reg[65:0], 66'b0};
            end
            S_LL: begin
                mul_a   = {1'b0, m_reg[32:0]};
                mul_b   = {1'b0, m_reg[32:0]};
                acc_add = {32'b0, prod_reg[65:0], 34'b0};
            end
            S_ACC: acc_add = {66'b0, prod_reg[65:0]};
            default: ;
        endcase
    end

    assign diff    = {p1_reg[67], p1_reg} - {prod_reg[67], prod_reg};
    assign mabs    = diff[68] ? -diff : diff;
    assign shifted = {rem_reg, rad_reg[95:94]};
    assign trial   = shifted - {2'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= A_IDLE;
            sub_reg  <= S_P1;
            comp_reg <= CMP_X;
            done_reg <= 1'b0;
        end else begin
            prod_reg <= mul_a * mul_b;
            unique case (ph_reg)
                A_IDLE: begin
                    if (start) begin
                        ux_reg   <= {vtx.b_x[31], vtx.b_x} - {vtx.a_x[31], vtx.a_x};
                        uy_reg   <= {vtx.b_y[31], vtx.b_y} - {vtx.a_y[31], vtx.a_y};
                        uz_reg   <= {vtx.b_z[31], vtx.b_z} - {vtx.a_z[31], vtx.a_z};
                        vx_reg   <= {vtx.c_x[31], vtx.c_x} - {vtx.a_x[31], vtx.a_x};
                        vy_reg   <= {vtx.c_y[31], vtx.c_y} - {vtx.a_y[31], vtx.a_y};
                        vz_reg   <= {vtx.c_z[31], vtx.c_z} - {vtx.a_z[31], vtx.a_z};
                        acc_reg  <= '0;
                        sub_reg  <= S_P1;
                        comp_reg <= CMP_X;
                        done_reg <= 1'b0;
                        ph_reg   <= A_CROSS;
                    end
                end
                A_CROSS: begin
                    acc_reg <= acc_reg + acc_add;
                    unique case (sub_reg)
                        S_P1:   sub_reg <= S_P2;
                        S_P2:   begin p1_reg <= prod_reg; sub_reg <= S_DIFF; end
                        S_DIFF: begin m_reg <= mabs[64:0]; sub_reg <= S_HH; end
                        S_HH:   sub_reg <= S_HL;
                        S_HL:   sub_reg <= S_LL;
                        S_LL:   sub_reg <= S_ACC;
                        S_ACC: begin
                            sub_reg <= S_P1;
                            if (comp_reg == CMP_Z) ph_reg <= A_LOAD;
                            else comp_reg <= comp_reg + 1'b1;
                        end
                        default: sub_reg <= S_P1;
                    endcase
                end
                A_LOAD: begin
                    // radicand is the squared norm over 2^34
                    sat_reg  <= |acc_reg[131:130];
                    rad_reg  <= acc_reg[129:34];
                    rem_reg  <= '0;
                    root_reg <= '0;
                    it_reg   <= '0;
                    ph_reg   <= A_SQRT;
                end
                A_SQRT: begin
                    rad_reg <= {rad_reg[93:0], 2'b00};
                    if (!trial[51]) begin
                        rem_reg  <= trial[49:0];
                        root_reg <= {root_reg[46:0], 1'b1};
                    end else begin
                        rem_reg  <= shifted[49:0];
                        root_reg <= {root_reg[46:0], 1'b0};
                    end
                    if (it_reg == 6'(SQRT_STEPS - 1)) begin
                        done_reg <= 1'b1;
                        ph_reg   <= A_IDLE;
                    end else begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                default: ph_reg <= A_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign area = sat_reg ? foah_pkg::AREA_MAX : root_reg;

endmodule

[hdl/foah_queue.sv]
// two-entry queue between the classify front and the accumulate back
`timescale 1ns / 1ps
module foah_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  foah_pkg::qent_t  wr_ent,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output foah_pkg::qent_t  rd_ent
);
    localparam int DEPTH = 2;

    foah_pkg::qent_t ent_reg [DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                ent_reg[wr_ptr_reg] <= wr_ent;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign full   = (cnt_reg == 2'(DEPTH));
    assign empty  = (cnt_reg == 2'd0);
    assign rd_ent = ent_reg[rd_ptr_reg];

endmodule

[hdl/foah_back.sv]
// per-bin totals: read-modify-write with saturating add and output register
`timescale 1ns / 1ps
module foah_back #(
    parameter int BINS = 37
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  foah_pkg::qent_t                 q_ent,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [foah_pkg::BIN_W-1:0]      m_bin_index,
    output logic [foah_pkg::AREA_W-1:0]     m_triangle_area,
    output logic [foah_pkg::TOTAL_W-1:0]    m_bin_total
);
    localparam int IW = $clog2(BINS);

    typedef enum logic [1:0] {B_IDLE, B_READ, B_ADD} bst_t;

    bst_t            st_reg;
    foah_pkg::qent_t cur_reg;
    logic [foah_pkg::TOTAL_W-1:0] mem [BINS];
    logic [foah_pkg::TOTAL_W-1:0] rdata_reg;
    logic [BINS-1:0] vld_reg;
    logic            rvld_reg;
    logic            wr_en;
    logic [IW-1:0]   idx;
    logic [foah_pkg::TOTAL_W:0]   sum;
    logic [foah_pkg::TOTAL_W-1:0] old_tot, new_tot;
    logic            out_vld_reg;

    assign idx     = cur_reg.bin[IW-1:0];
    assign old_tot = rvld_reg ? rdata_reg : '0;
    assign sum     = {1'b0, old_tot} + {{(foah_pkg::TOTAL_W-foah_pkg::AREA_W+1){1'b0}},
                                        cur_reg.area};
    assign new_tot = sum[foah_pkg::TOTAL_W] ? {foah_pkg::TOTAL_W{1'b1}}
                                             : sum[foah_pkg::TOTAL_W-1:0];
    assign wr_en   = (st_reg == B_ADD) && (!out_vld_reg || m_ready);
    assign q_pop   = (st_reg == B_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[idx] <= new_tot;
        if (st_reg == B_READ) rdata_reg <= mem[idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= B_IDLE;
            vld_reg     <= '0;
            rvld_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (out_vld_reg && m_ready && !wr_en) out_vld_reg <= 1'b0;
            unique case (st_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        cur_reg <= q_ent;
                        st_reg  <= B_READ;
                    end
                end
                B_READ: begin
                    rvld_reg <= vld_reg[idx];
                    st_reg   <= B_ADD;
                end
                B_ADD: begin
                    if (wr_en) begin
                        vld_reg[idx]    <= 1'b1;
                        out_vld_reg     <= 1'b1;
                        m_bin_index     <= cur_reg.bin;
                        m_triangle_area <= cur_reg.area;
                        m_bin_total     <= new_tot;
                        st_reg          <= B_IDLE;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    assign m_valid = out_vld_reg;

endmodule

[hdl/facet_orientation_area_histogram.sv]
// top level: facet orientation / area histogram with decoupled classify and accumulate
`timescale 1ns / 1ps
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    normal_x/y/z, vertices a_*, b_*, c_*
// m_        out        m_valid / m_ready    bin_index, triangle_area, bin_total
//
// the front takes one triangle at a time: a capture, cross product squaring on
// the shared 34x34 multiplier, a load and a bit-serial square root; the bin scan
// runs alongside. the back steps through idle, read and add per transaction, so
// the root sets the rate.
// reset is synchronous, active low; bin totals read as zero until first written.
// a stalled m_ready fills the two-entry queue, then holds the front.
module facet_orientation_area_histogram #(
    parameter int BINS = 37
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [foah_pkg::NRM_W-1:0]      s_normal_x,
    input  logic signed [foah_pkg::NRM_W-1:0]      s_normal_y,
    input  logic signed [foah_pkg::NRM_W-1:0]      s_normal_z,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_a_x,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_a_y,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_a_z,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_b_x,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_b_y,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_b_z,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_c_x,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_c_y,
    input  logic signed [foah_pkg::CRD_W-1:0]      s_c_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [foah_pkg::BIN_W-1:0]             m_bin_index,
    output logic [foah_pkg::AREA_W-1:0]            m_triangle_area,
    output logic [foah_pkg::TOTAL_W-1:0]           m_bin_total
);
    logic            busy_reg;
    logic            start;
    logic            bin_done, area_done;
    logic [foah_pkg::BIN_W-1:0]  bin;
    logic [foah_pkg::AREA_W-1:0] area;
    foah_pkg::vtx_t  vtx;
    foah_pkg::qent_t q_wr, q_rd;
    logic            q_full, q_empty, q_push, q_pop;

    // front accepts a transaction only when no triangle is being classified
    assign s_ready = !busy_reg;
    assign start   = s_valid && !busy_reg;

    assign vtx = '{a_x: s_a_x, a_y: s_a_y, a_z: s_a_z,
                   b_x: s_b_x, b_y: s_b_y, b_z: s_b_z,
                   c_x: s_c_x, c_y: s_c_y, c_z: s_c_z};

    // hand the classified triangle to the queue once both units finish
    assign q_push = busy_reg && bin_done && area_done && !q_full;
    assign q_wr   = '{bin: bin, area: area};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            if (start) busy_reg <= 1'b1;
            else if (q_push) busy_reg <= 1'b0;
        end
    end

    foah_binsel #(.BINS(BINS)) u_binsel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .nx      (s_normal_x),
        .ny      (s_normal_y),
        .nz      (s_normal_z),
        .done    (bin_done),
        .bin     (bin)
    );

    foah_area u_area (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .vtx     (vtx),
        .done    (area_done),
        .area    (area)
    );

    foah_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_ent  (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_ent  (q_rd)
    );

    foah_back #(.BINS(BINS)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_ent           (q_rd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bin_index     (m_bin_index),
        .m_triangle_area (m_triangle_area),
        .m_bin_total     (m_bin_total)
    );

`ifndef NO_ASSERTIONS
    // one triangle in the front at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front took a second triangle while busy");

    // finished front frees up after handing off
    a_push_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && bin_done && area_done && !q_full |=> s_ready)
        else $error("front did not release after queue push");

    // a running total includes the area just added
    a_total_covers_area: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bin_total >= {16'b0, m_triangle_area}))
        else $error("bin total below triangle area");

    // bin stays inside the histogram
    a_bin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bin_index <= foah_pkg::BIN_W'(BINS - 1)))
        else $error("bin index out of range");
`endif

endmodule
